// ===== rtl/sha1_pkg.sv =====
// Shared types and constants of the SHA-1 hash engine.
`default_nettype none

package sha1_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned HashW   = 5;
  localparam int unsigned BlkW    = 16;
  localparam int unsigned PosW    = 6;
  localparam int unsigned LenW    = 64;
  localparam int unsigned RndW    = 7;

  localparam logic [RndW-1:0] LastRound = 7'd79;
  localparam logic [2:0]      LastIdx   = 3'd4;
  localparam logic [PosW-1:0] LenPos    = 6'd56;
  localparam logic [PosW-1:0] FullPos   = 6'd63;
  localparam logic [7:0]      PadByte   = 8'h80;

  localparam logic [WordW-1:0] K0 = 32'h5A827999;
  localparam logic [WordW-1:0] K1 = 32'h6ED9EBA1;
  localparam logic [WordW-1:0] K2 = 32'h8F1BBCDC;
  localparam logic [WordW-1:0] K3 = 32'hCA62C1D6;

  localparam logic [HashW-1:0][WordW-1:0] InitHash = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  // Buffer and hash operations requested of the compression core.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_BYTE,
    OP_PAD,
    OP_ZERO,
    OP_LEN,
    OP_START,
    OP_INIT
  } sha1_op_e;

  typedef struct packed {
    sha1_op_e        op;
    logic [PosW-1:0] pos;
    logic [7:0]      data;
    logic [LenW-1:0] len;
  } sha1_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/sha1_core.sv =====
// Block buffer, message schedule and iterative 80-round SHA-1 compression.
`default_nettype none

module sha1_core (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire sha1_pkg::sha1_cmd_t cmd_i,
  output logic                     busy_o,
  output logic [sha1_pkg::HashW-1:0][sha1_pkg::WordW-1:0] hash_o
);
  import sha1_pkg::*;

  typedef enum logic [1:0] {
    C_IDLE,
    C_RUN,
    C_ADD
  } core_state_e;

  core_state_e                       state_q;
  logic [RndW-1:0]                   rnd_q;
  logic [HashW-1:0][WordW-1:0]       h_q;
  logic [WordW-1:0]                  a_q, b_q, c_q, d_q, e_q;
  logic [BlkW-1:0][WordW-1:0]        w_q, w_d;

  logic [WordW-1:0] w_new, x_fb, f_val, k_val, t_val;
  logic [3:0]       widx;
  logic [4:0]       lane_sh;
  logic [4:0]       keep_sh;
  logic [WordW-1:0] keep_mask;

  assign busy_o = (state_q != C_IDLE);
  assign hash_o = h_q;

  assign widx      = cmd_i.pos[5:2];
  assign lane_sh   = {~cmd_i.pos[1:0], 3'b000};
  assign keep_sh   = {cmd_i.pos[1:0], 3'b000};
  assign keep_mask = ~(32'hFFFF_FFFF >> keep_sh);

  // Schedule window holds W[t-16..t-1]; the first 16 rounds just rotate it.
  assign x_fb  = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
  assign w_new = (rnd_q < 7'd16) ? w_q[0] : {x_fb[30:0], x_fb[31]};

  always_comb begin
    if (rnd_q < 7'd20) begin
      f_val = (b_q & c_q) | (~b_q & d_q);
      k_val = K0;
    end else if (rnd_q < 7'd40) begin
      f_val = b_q ^ c_q ^ d_q;
      k_val = K1;
    end else if (rnd_q < 7'd60) begin
      f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k_val = K2;
    end else begin
      f_val = b_q ^ c_q ^ d_q;
      k_val = K3;
    end
  end

  assign t_val = {a_q[26:0], a_q[31:27]} + f_val + e_q + k_val + w_new;

  always_comb begin
    w_d = w_q;
    if (state_q == C_RUN) begin
      for (int i = 0; i < BlkW - 1; i++) begin
        w_d[i] = w_q[i+1];
      end
      w_d[BlkW-1] = w_new;
    end else if (state_q == C_IDLE) begin
      case (cmd_i.op)
        OP_BYTE: begin
          w_d[widx][lane_sh +: 8] = cmd_i.data;
        end
        OP_PAD: begin
          // Keep bytes before the marker, place 0x80, clear the rest of the block.
          for (int i = 0; i < BlkW; i++) begin
            if (4'(i) > widx) begin
              w_d[i] = '0;
            end else if (4'(i) == widx) begin
              w_d[i] = (w_q[i] & keep_mask) | ({24'b0, PadByte} << lane_sh);
            end
          end
        end
        OP_ZERO: begin
          w_d = '0;
        end
        OP_LEN: begin
          w_d[14] = cmd_i.len[63:32];
          w_d[15] = cmd_i.len[31:0];
        end
        default: begin
          w_d = w_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      rnd_q   <= '0;
      h_q     <= InitHash;
    end else begin
      unique case (state_q)
        C_IDLE: begin
          if (cmd_i.op == OP_START) begin
            state_q <= C_RUN;
            rnd_q   <= '0;
          end else if (cmd_i.op == OP_INIT) begin
            h_q <= InitHash;
          end
        end
        C_RUN: begin
          rnd_q <= rnd_q + 7'd1;
          if (rnd_q == LastRound) begin
            state_q <= C_ADD;
          end
        end
        C_ADD: begin
          h_q[0]  <= h_q[0] + a_q;
          h_q[1]  <= h_q[1] + b_q;
          h_q[2]  <= h_q[2] + c_q;
          h_q[3]  <= h_q[3] + d_q;
          h_q[4]  <= h_q[4] + e_q;
          state_q <= C_IDLE;
        end
        default: begin
          state_q <= C_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
    if (state_q == C_IDLE && cmd_i.op == OP_START) begin
      a_q <= h_q[0];
      b_q <= h_q[1];
      c_q <= h_q[2];
      d_q <= h_q[3];
      e_q <= h_q[4];
    end else if (state_q == C_RUN) begin
      a_q <= t_val;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sha1_hash_engine.sv =====
// SHA-1 hash engine top level: byte intake, padding sequencer and digest output.
`default_nettype none

// Absorb beats (tuser 0) carry one message byte each; every 64th byte starts
// a compression that holds the input until it is done. The single round unit
// in sha1_core does one of 80 rounds per cycle, between the load and the final
// add. A finish beat (tuser 1) pads the buffer and runs one final compression,
// or two when 56 or more bytes are held, then presents the five digest words,
// word 0 first, tlast on the fifth. After the fifth beat the engine is back in
// its initial hash state.
module sha1_hash_engine (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tuser,   // [0] func
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
  output logic             m_axis_tlast    // last_word
);
  import sha1_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BLK,
    ST_WBLK,
    ST_PAD,
    ST_WPAD,
    ST_ZERO,
    ST_LEN,
    ST_LAST,
    ST_WLAST,
    ST_OUT
  } eng_state_e;

  eng_state_e       state_q;
  logic [PosW-1:0]  fill_q;
  logic [LenW-1:0]  total_q;
  logic [2:0]       idx_q;

  sha1_cmd_t                   cmd;
  logic                        core_busy;
  logic [HashW-1:0][WordW-1:0] hash;
  logic                        in_beat, out_beat;
  logic [WordW-1:0]            digest;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign out_beat      = m_axis_tvalid && m_axis_tready;

  always_comb begin
    cmd.op   = OP_NONE;
    cmd.pos  = fill_q;
    cmd.data = s_axis_tdata;
    cmd.len  = {total_q[LenW-4:0], 3'b000};
    unique case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          cmd.op = s_axis_tuser ? OP_PAD : OP_BYTE;
        end
      end
      ST_BLK:   cmd.op = OP_START;
      ST_PAD:   cmd.op = (fill_q >= LenPos) ? OP_START : OP_LEN;
      ST_ZERO:  cmd.op = OP_ZERO;
      ST_LEN:   cmd.op = OP_LEN;
      ST_LAST:  cmd.op = OP_START;
      ST_OUT: begin
        if (out_beat && idx_q == LastIdx) begin
          cmd.op = OP_INIT;
        end
      end
      default:  cmd.op = OP_NONE;
    endcase
  end

  sha1_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .busy_o (core_busy),
    .hash_o (hash)
  );

  always_comb begin
    case (idx_q)
      3'd0:    digest = hash[0];
      3'd1:    digest = hash[1];
      3'd2:    digest = hash[2];
      3'd3:    digest = hash[3];
      3'd4:    digest = hash[4];
      default: digest = '0;
    endcase
  end

  assign m_axis_tdata = {5'b0, idx_q, digest};
  assign m_axis_tlast = (idx_q == LastIdx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      total_q <= '0;
      idx_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_beat) begin
            if (s_axis_tuser) begin
              state_q <= ST_PAD;
            end else begin
              total_q <= total_q + 64'd1;
              fill_q  <= fill_q + 6'd1;
              if (fill_q == FullPos) begin
                state_q <= ST_BLK;
              end
            end
          end
        end
        ST_BLK:  state_q <= ST_WBLK;
        ST_WBLK: begin
          if (!core_busy) begin
            state_q <= ST_IDLE;
          end
        end
        ST_PAD: begin
          // Length does not fit behind the marker: flush this block first.
          state_q <= (fill_q >= LenPos) ? ST_WPAD : ST_LAST;
        end
        ST_WPAD: begin
          if (!core_busy) begin
            state_q <= ST_ZERO;
          end
        end
        ST_ZERO:  state_q <= ST_LEN;
        ST_LEN:   state_q <= ST_LAST;
        ST_LAST:  state_q <= ST_WLAST;
        ST_WLAST: begin
          if (!core_busy) begin
            state_q <= ST_OUT;
            idx_q   <= '0;
          end
        end
        ST_OUT: begin
          if (out_beat) begin
            idx_q <= idx_q + 3'd1;
            if (idx_q == LastIdx) begin
              state_q <= ST_IDLE;
              fill_q  <= '0;
              total_q <= '0;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== dv/sha1_tb_pkg.sv =====
// Input function codes shared by the SHA-1 engine testbench and its checker.
package sha1_tb_pkg;

  // Function carried in s_axis_tuser.
  typedef enum logic {
    FUNC_ABSORB = 1'b0,
    FUNC_FINISH = 1'b1
  } sha1_func_e;

endpackage

// ===== dv/sha1_digest_checker.sv =====
// Digest checker: models the SHA-1 engine from accepted input beats and compares output beats.
module sha1_digest_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,   // [7:0] data_byte
  input  logic        s_tuser_i,   // [0] func
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [39:0] m_tdata_i,   // [31:0] digest_word, [34:32] word_index
  input  logic        m_tlast_i,   // last_word
  output int          err_cnt_o,
  output int          words_due_o,
  output int          words_checked_o,
  output int          digests_done_o,
  output int          spill_msgs_o
);
  import sha1_pkg::*;
  import sha1_tb_pkg::*;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic [2:0]       idx;
    logic             last;
  } digest_beat_t;

  digest_beat_t digest_q[$];
  digest_beat_t got_beat;
  digest_beat_t want_beat;

  logic [WordW-1:0] hash_st  [HashW];
  logic [WordW-1:0] blk_buf  [BlkW];
  logic [PosW-1:0]  fill_cnt;
  logic [LenW-1:0]  msg_bytes;

  function automatic void restart_hash();
    for (int i = 0; i < HashW; i++) hash_st[i] = InitHash[i];
    for (int i = 0; i < BlkW; i++) blk_buf[i] = '0;
    fill_cnt  = '0;
    msg_bytes = '0;
  endfunction

  // Byte lanes are big-endian within each buffer word.
  function automatic void put_byte(int pos, logic [7:0] val);
    blk_buf[pos >> 2][(3 - (pos & 3)) * 8 +: 8] = val;
  endfunction

  function automatic void compress_block();
    logic [WordW-1:0] w [80];
    logic [WordW-1:0] a, b, c, d, e, f, k, t;
    for (int r = 0; r < 16; r++) w[r] = blk_buf[r];
    for (int r = 16; r < 80; r++) begin
      t    = w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16];
      w[r] = {t[30:0], t[31]};
    end
    a = hash_st[0]; b = hash_st[1]; c = hash_st[2]; d = hash_st[3]; e = hash_st[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d); k = K0;
      end else if (r < 40) begin
        f = b ^ c ^ d; k = K1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d); k = K2;
      end else begin
        f = b ^ c ^ d; k = K3;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[r];
      e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = t;
    end
    hash_st[0] += a; hash_st[1] += b; hash_st[2] += c;
    hash_st[3] += d; hash_st[4] += e;
  endfunction

  function automatic void absorb_byte(logic [7:0] val);
    put_byte(int'(fill_cnt), val);
    msg_bytes++;
    if (fill_cnt == FullPos) begin
      compress_block();
      fill_cnt = '0;
    end else begin
      fill_cnt++;
    end
  endfunction

  // Pad, append the bit length, and queue the five digest words.
  function automatic void finish_message();
    int               pos;
    logic [LenW-1:0]  bit_len;
    digest_beat_t     beat;
    pos     = int'(fill_cnt);
    bit_len = msg_bytes << 3;
    put_byte(pos, PadByte);
    for (int i = pos + 1; i < 64; i++) put_byte(i, 8'h00);
    if (fill_cnt >= LenPos) begin
      compress_block();
      for (int i = 0; i < BlkW; i++) blk_buf[i] = '0;
      spill_msgs_o++;
    end
    blk_buf[14] = bit_len[63:32];
    blk_buf[15] = bit_len[31:0];
    compress_block();
    for (int i = 0; i < HashW; i++) begin
      beat.word = hash_st[i];
      beat.idx  = 3'(i);
      beat.last = (3'(i) == LastIdx);
      digest_q.push_back(beat);
    end
    restart_hash();
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_hash();
      digest_q.delete();
      err_cnt_o       = 0;
      words_due_o     <= 0;
      words_checked_o = 0;
      digests_done_o  = 0;
      spill_msgs_o    = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got_beat.word = m_tdata_i[31:0];
        got_beat.idx  = m_tdata_i[34:32];
        got_beat.last = m_tlast_i;
        if (digest_q.size() == 0) begin
          err_cnt_o++;
          $display("%0t: digest beat with nothing pending: expected none, got %h idx %0d last %b",
                   $time, got_beat.word, got_beat.idx, got_beat.last);
        end else begin
          want_beat = digest_q.pop_front();
          if (got_beat.word !== want_beat.word) begin
            err_cnt_o++;
            $display("%0t: digest_word mismatch at idx %0d: expected %h, got %h",
                     $time, want_beat.idx, want_beat.word, got_beat.word);
          end
          if (got_beat.idx !== want_beat.idx) begin
            err_cnt_o++;
            $display("%0t: word_index mismatch: expected %0d, got %0d",
                     $time, want_beat.idx, got_beat.idx);
          end
          if (got_beat.last !== want_beat.last) begin
            err_cnt_o++;
            $display("%0t: last_word mismatch at idx %0d: expected %b, got %b",
                     $time, want_beat.idx, want_beat.last, got_beat.last);
          end
          words_checked_o++;
          if (want_beat.last) digests_done_o++;
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        if (sha1_func_e'(s_tuser_i) == FUNC_FINISH) finish_message();
        else absorb_byte(s_tdata_i);
      end
      words_due_o <= digest_q.size();
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the SHA-1 hash engine: clock, reset, stream stimulus and verdict.
module tb_top;
  import sha1_tb_pkg::*;

  localparam int RandItems  = 320;
  localparam int MinDigests = 12;
  localparam int HoldCycles = 400;
  localparam int IdlePct    = 36;
  localparam int DrainCycles = 200;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tuser  = FUNC_ABSORB;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  int err_cnt, words_due, words_checked, digests_done, spill_msgs;
  int beats_sent;

  sha1_hash_engine dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  sha1_digest_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_tvalid_i     (s_axis_tvalid),
    .s_tready_i     (s_axis_tready),
    .s_tdata_i      (s_axis_tdata),
    .s_tuser_i      (s_axis_tuser),
    .m_tvalid_i     (m_axis_tvalid),
    .m_tready_i     (m_axis_tready),
    .m_tdata_i      (m_axis_tdata),
    .m_tlast_i      (m_axis_tlast),
    .err_cnt_o      (err_cnt),
    .words_due_o    (words_due),
    .words_checked_o(words_checked),
    .digests_done_o (digests_done),
    .spill_msgs_o   (spill_msgs)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("tb_top failed");
    $finish;
  end

  // Random idle cycles, except for a calm stretch of beats in the middle.
  task automatic send_beat(sha1_func_e fn, logic [7:0] val);
    bit calm;
    calm = (beats_sent >= 150) && (beats_sent < 230);
    if (!calm && ($urandom_range(99) < IdlePct)) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < IdlePct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= fn;
    s_axis_tdata  <= val;
    do @(posedge clk_i); while (!s_axis_tready);
    beats_sent++;
  endtask

  // The finish beat carries a random byte, which the engine must ignore.
  task automatic send_message(int len);
    for (int i = 0; i < len; i++) send_beat(FUNC_ABSORB, 8'($urandom));
    send_beat(FUNC_FINISH, 8'($urandom));
  endtask

  // Mostly short messages; the rest sit on the padding and block boundaries.
  function automatic int pick_length();
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) return $urandom_range(15);
    case ($urandom_range(7))
      0:       return 55;
      1:       return 56;
      2:       return 57;
      3:       return 63;
      4:       return 64;
      5:       return 65;
      6:       return 119;
      default: return 120;
    endcase
  endfunction

  // Receiver: random back-pressure, a calm window, and one long hold-off.
  initial begin
    int  cyc;
    int  hold_left;
    bit  held;
    cyc       = 0;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!held && m_axis_tvalid && digests_done >= 5) begin
        held      = 1'b1;
        hold_left = HoldCycles - 1;
        m_axis_tready <= 1'b0;
      end else if (cyc >= 1500 && cyc < 3500) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= IdlePct);
      end
    end
  end

  initial begin
    int msg_no;
    int first_rand;
    beats_sent = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty message, then "abc", then single bytes at both extremes.
    send_beat(FUNC_FINISH, 8'hFF);
    send_beat(FUNC_ABSORB, 8'h61);
    send_beat(FUNC_ABSORB, 8'h62);
    send_beat(FUNC_ABSORB, 8'h63);
    send_beat(FUNC_FINISH, 8'h00);
    send_beat(FUNC_ABSORB, 8'h00);
    send_beat(FUNC_FINISH, 8'h00);
    send_beat(FUNC_ABSORB, 8'hFF);
    send_beat(FUNC_FINISH, 8'hFF);
    send_beat(FUNC_ABSORB, 8'h55);
    send_beat(FUNC_ABSORB, 8'hAA);
    send_beat(FUNC_FINISH, 8'h5A);
    // Back-to-back finish: a second empty message.
    send_beat(FUNC_FINISH, 8'hA5);

    first_rand = beats_sent;
    msg_no     = 0;
    while ((beats_sent - first_rand) < RandItems || digests_done + words_due / 5 < MinDigests)
    begin
      if (msg_no == 6) begin
        s_axis_tvalid <= 1'b0;
        do @(posedge clk_i); while (words_due != 0);
      end
      send_message(pick_length());
      msg_no++;
    end
    s_axis_tvalid <= 1'b0;

    do @(posedge clk_i); while (words_due != 0);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d beats in %0d messages; checked %0d digests (%0d words),",
             beats_sent, msg_no + 6, digests_done, words_checked);
    $display("%0d of them with the length spilling into a second padded block.", spill_msgs);
    if (err_cnt == 0 && words_due == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
